FILE: design/odo_pkg.sv
// Shared types, constants and arithmetic helpers of the differential drive odometry unit.
package odo_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int CORDIC_FRAC = 30;
  localparam int SHIFT_DIST  = 25 - FRAC_BITS;
  localparam int SHIFT_TURN  = 24 - FRAC_BITS;
  localparam int SHIFT_ANG   = CORDIC_FRAC - FRAC_BITS;
  localparam int SHIFT_POS   = FRAC_BITS;

  localparam logic signed [20:0] PI_Q     = 21'sd205887;
  localparam logic signed [20:0] TWO_PI_Q = 21'sd411774;

  localparam logic signed [33:0] HALF_PI_Q30    = 34'sd1686629713;
  localparam logic signed [33:0] PI_Q30         = 34'sd3373259426;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  localparam logic signed [37:0] DIST_LIMIT = 38'sh1F_FFFF_FFFF;

  localparam logic CFG_DPC = 1'b0;
  localparam logic CFG_RPC = 1'b1;

  typedef enum logic [2:0] {
    OP_DIST = 3'd0,
    OP_TURN = 3'd1,
    OP_VEL  = 3'd2,
    OP_RATE = 3'd3,
    OP_XPOS = 3'd4,
    OP_YPOS = 3'd5
  } mul_op_e;

  typedef struct packed {
    logic    load;
    logic    rot_en;
    logic [4:0] rot_idx;
    logic    mul_en;
    mul_op_e mul_op;
    logic    wb_en;
    mul_op_e wb_op;
    logic    out_load;
  } odo_cmd_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
    logic signed [33:0] r;
    case (idx)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021687;
      5'd5:  r = 34'sd33543516;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048576;
      5'd11: r = 34'sd524288;
      5'd12: r = 34'sd262144;
      5'd13: r = 34'sd131072;
      5'd14: r = 34'sd65536;
      5'd15: r = 34'sd32768;
      5'd16: r = 34'sd16384;
      5'd17: r = 34'sd8192;
      5'd18: r = 34'sd4096;
      5'd19: r = 34'sd2048;
      5'd20: r = 34'sd1024;
      5'd21: r = 34'sd512;
      5'd22: r = 34'sd256;
      5'd23: r = 34'sd128;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  // Round to nearest, halves toward +infinity.
  function automatic logic signed [62:0] round_shr(input logic signed [62:0] v,
                                                   input logic [4:0] s);
    logic signed [62:0] half;
    half = 63'sd1 <<< (s - 5'd1);
    return (v + half) >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [62:0] v);
    logic signed [31:0] r;
    if (v > 63'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -63'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

FILE: design/differential_drive_odometry_unit.sv
// Top level of the differential drive odometry unit.
//
// One sample enters on the slave stream: absolute left and right encoder
// counts and wheel speeds. One result leaves on the master stream: X, Y,
// heading (all Q16), linear and angular velocity. Two write-only registers
// set meters per count (index 0) and radians per count (index 1), Q0.24.
// Write them only while the block is idle.
//
// A sample runs through the iterative rotation CORDIC, one step per cycle,
// followed by six products through one shared 38x25 multiplier. A new
// sample is not taken before the previous one is done: input tready is
// high only while the sequencer is idle.
//
// The result sits in an output register: a new sample is accepted while the
// previous result waits; if the receiver still stalls when the next result
// is done, the sequencer holds it until the register empties.
// Reset clears pose, previous counts and both registers to zero; the first
// sample after reset takes its count deltas against zero.
module differential_drive_odometry_unit import odo_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // left_count[31:0], right_count[63:32], left_speed[79:64], right_speed[95:80]
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // x_position[31:0], y_position[63:32], heading_angle[82:64],
  // linear_velocity[114:83], angular_velocity[146:115], zero[151:147]
  output logic [151:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic         cfg_addr_i,
  input  logic [23:0]  cfg_wdata_i
);

  odo_cmd_t           cmd;
  logic signed [31:0] x_pos, y_pos, lin_vel, ang_vel;
  logic signed [18:0] heading;

  odo_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cmd_o      (cmd)
  );

  odo_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .cfg_we_i           (cfg_we_i),
    .cfg_addr_i         (cfg_addr_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .left_count_i       (s_axis_tdata[31:0]),
    .right_count_i      (s_axis_tdata[63:32]),
    .left_speed_i       (s_axis_tdata[79:64]),
    .right_speed_i      (s_axis_tdata[95:80]),
    .x_position_o       (x_pos),
    .y_position_o       (y_pos),
    .heading_angle_o    (heading),
    .linear_velocity_o  (lin_vel),
    .angular_velocity_o (ang_vel)
  );

  // Pack the result; pad to whole bytes with zeros.
  assign m_axis_tdata = {5'b0, ang_vel, lin_vel, heading, y_pos, x_pos};

endmodule

FILE: design/odo_ctrl.sv
// Sequencer of the odometry unit: input and output handshakes, CORDIC and multiply steps.
module odo_ctrl import odo_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_tvalid_i,
  output logic     s_tready_o,
  output logic     m_tvalid_o,
  input  logic     m_tready_i,
  output odo_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROT   = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  localparam logic [4:0] LAST_ROT = 5'(CORDIC_STEPS - 1);

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       s_fire;

  assign s_tready_o = (state_q == ST_IDLE);
  assign s_fire     = s_tvalid_i && s_tready_o;
  assign m_tvalid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !m_tready_i;
    cmd_o       = '0;
    cmd_o.mul_op = OP_DIST;
    cmd_o.wb_op  = OP_DIST;
    cmd_o.rot_idx = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_ROT;
        end
      end
      ST_ROT: begin
        cmd_o.rot_en = 1'b1;
        if (cnt_q == LAST_ROT) begin
          cnt_d   = '0;
          state_d = ST_MUL;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = mul_op_e'(cnt_q[2:0]);
        cmd_o.wb_en  = (cnt_q != 5'd0);
        cmd_o.wb_op  = mul_op_e'(cnt_q[2:0] - 3'd1);
        cnt_d        = cnt_q + 5'd1;
        if (cnt_q[2:0] == OP_YPOS) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd_o.wb_en = 1'b1;
        cmd_o.wb_op = OP_YPOS;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_q || m_tready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_starts_rot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> state_q == ST_ROT) else $error("accepted sample did not start CORDIC");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || m_tready_i)) else $error("result overwritten");
  a_rot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROT |-> cnt_q <= LAST_ROT) else $error("CORDIC step out of range");
  a_mul_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul_en |-> cnt_q <= 5'd5) else $error("multiply step out of range");

endmodule

FILE: design/odo_dp.sv
// Datapath of the odometry unit: state, CORDIC rotator, shared multiplier and output register.
module odo_dp import odo_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  odo_cmd_t           cmd_i,
  input  logic               cfg_we_i,
  input  logic               cfg_addr_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic [31:0]        left_count_i,
  input  logic [31:0]        right_count_i,
  input  logic signed [15:0] left_speed_i,
  input  logic signed [15:0] right_speed_i,
  output logic signed [31:0] x_position_o,
  output logic signed [31:0] y_position_o,
  output logic signed [18:0] heading_angle_o,
  output logic signed [31:0] linear_velocity_o,
  output logic signed [31:0] angular_velocity_o
);

  logic [23:0]        dpc_q, rpc_q;
  logic [31:0]        prev_l_q, prev_r_q;
  logic signed [31:0] x_q, x_d, y_q, y_d;
  logic signed [18:0] hd_q, hd_d;
  logic signed [32:0] sum_q, diff_q;
  logic signed [16:0] ssum_q, sdiff_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic               flip_q;
  logic signed [62:0] prod_q;
  logic signed [37:0] dist_q;
  logic signed [31:0] vel_q, rate_q;

  logic signed [31:0] dl, dr;
  logic signed [33:0] z0, cx_sh, cy_sh, at, cr, sr;
  logic signed [37:0] op_a;
  logic signed [24:0] op_b;
  logic [4:0]         sh;
  logic signed [62:0] rnd;
  logic signed [20:0] dh, h;

  assign dl = left_count_i - prev_l_q;
  assign dr = right_count_i - prev_r_q;
  assign z0 = 34'(hd_q) <<< SHIFT_ANG;

  assign cx_sh = cx_q >>> cmd_i.rot_idx;
  assign cy_sh = cy_q >>> cmd_i.rot_idx;
  assign at    = atan_q30(cmd_i.rot_idx);

  // Cosine and sine back to Q16, with the half-turn fold undone.
  always_comb begin
    cr = (cx_q + (34'sd1 <<< (SHIFT_ANG - 1))) >>> SHIFT_ANG;
    sr = (cy_q + (34'sd1 <<< (SHIFT_ANG - 1))) >>> SHIFT_ANG;
    if (flip_q) begin
      cr = -cr;
      sr = -sr;
    end
  end

  always_comb begin
    case (cmd_i.mul_op)
      OP_DIST: begin op_a = 38'(sum_q);   op_b = $signed({1'b0, dpc_q}); end
      OP_TURN: begin op_a = 38'(diff_q);  op_b = $signed({1'b0, rpc_q}); end
      OP_VEL:  begin op_a = 38'(ssum_q);  op_b = $signed({1'b0, dpc_q}); end
      OP_RATE: begin op_a = 38'(sdiff_q); op_b = $signed({1'b0, rpc_q}); end
      OP_XPOS: begin op_a = dist_q;       op_b = 25'(cr); end
      OP_YPOS: begin op_a = dist_q;       op_b = 25'(sr); end
      default: begin op_a = '0;           op_b = '0; end
    endcase
  end

  always_comb begin
    case (cmd_i.wb_op)
      OP_DIST, OP_VEL:   sh = 5'(SHIFT_DIST);
      OP_TURN, OP_RATE:  sh = 5'(SHIFT_TURN);
      OP_XPOS, OP_YPOS:  sh = 5'(SHIFT_POS);
      default:           sh = 5'(SHIFT_POS);
    endcase
  end

  assign rnd = round_shr(prod_q, sh);

  // Heading step clamp and single wrap into [-pi, pi).
  always_comb begin
    if (rnd > 63'(TWO_PI_Q - 21'sd1)) dh = TWO_PI_Q - 21'sd1;
    else if (rnd < -63'(TWO_PI_Q)) dh = -TWO_PI_Q;
    else dh = rnd[20:0];
    h = 21'(hd_q) + dh;
    if (h >= PI_Q) h = h - TWO_PI_Q;
    else if (h < -PI_Q) h = h + TWO_PI_Q;
  end

  always_comb begin
    x_d  = x_q;
    y_d  = y_q;
    hd_d = hd_q;
    if (cmd_i.wb_en) begin
      case (cmd_i.wb_op)
        OP_TURN: hd_d = h[18:0];
        OP_XPOS: x_d  = sat32(63'(x_q) + rnd);
        OP_YPOS: y_d  = sat32(63'(y_q) + rnd);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpc_q    <= '0;
      rpc_q    <= '0;
      prev_l_q <= '0;
      prev_r_q <= '0;
      x_q      <= '0;
      y_q      <= '0;
      hd_q     <= '0;
    end else begin
      if (cfg_we_i && cfg_addr_i == CFG_DPC) dpc_q <= cfg_wdata_i;
      if (cfg_we_i && cfg_addr_i == CFG_RPC) rpc_q <= cfg_wdata_i;
      if (cmd_i.load) begin
        prev_l_q <= left_count_i;
        prev_r_q <= right_count_i;
      end
      x_q  <= x_d;
      y_q  <= y_d;
      hd_q <= hd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sum_q   <= 33'(dl) + 33'(dr);
      diff_q  <= 33'(dr) - 33'(dl);
      ssum_q  <= 17'(left_speed_i) + 17'(right_speed_i);
      sdiff_q <= 17'(right_speed_i) - 17'(left_speed_i);
      cx_q    <= CORDIC_GAIN_Q30;
      cy_q    <= '0;
      if (z0 > HALF_PI_Q30) begin
        cz_q   <= z0 - PI_Q30;
        flip_q <= 1'b1;
      end else if (z0 < -HALF_PI_Q30) begin
        cz_q   <= z0 + PI_Q30;
        flip_q <= 1'b1;
      end else begin
        cz_q   <= z0;
        flip_q <= 1'b0;
      end
    end else if (cmd_i.rot_en) begin
      if (!cz_q[33]) begin
        cx_q <= cx_q - cy_sh;
        cy_q <= cy_q + cx_sh;
        cz_q <= cz_q - at;
      end else begin
        cx_q <= cx_q + cy_sh;
        cy_q <= cy_q - cx_sh;
        cz_q <= cz_q + at;
      end
    end
    if (cmd_i.mul_en) prod_q <= 63'(op_a) * 63'(op_b);
    if (cmd_i.wb_en) begin
      case (cmd_i.wb_op)
        OP_DIST: begin
          if (rnd > 63'(DIST_LIMIT)) dist_q <= DIST_LIMIT;
          else if (rnd < -63'(DIST_LIMIT)) dist_q <= -DIST_LIMIT;
          else dist_q <= rnd[37:0];
        end
        OP_VEL:  vel_q  <= sat32(rnd);
        OP_RATE: rate_q <= sat32(rnd);
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      x_position_o       <= x_q;
      y_position_o       <= y_q;
      heading_angle_o    <= hd_q;
      linear_velocity_o  <= vel_q;
      angular_velocity_o <= rate_q;
    end
  end

endmodule

FILE: dv/differential_drive_odometry_unit_tb.sv
// Self-checking testbench of the differential drive odometry unit.
module differential_drive_odometry_unit_tb;
  import odo_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] ang_vel;
    logic signed [31:0] lin_vel;
    logic signed [18:0] heading;
    logic signed [31:0] y_pos;
    logic signed [31:0] x_pos;
  } pose_t;

  localparam int STEPS = 16;
  localparam int DRAIN_CYCLES = 60;
  localparam longint PI_L = 205887;
  localparam longint DIST_MAX = (64'sd1 <<< 37) - 1;
  localparam longint I32_MIN = -64'sd2147483648;
  localparam longint I32_MAX = 64'sd2147483647;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [151:0] m_axis_tdata;
  logic         cfg_we_i;
  logic         cfg_addr_i;
  logic [23:0]  cfg_wdata_i;

  differential_drive_odometry_unit u_top (.*);

  // Shadow of the block's registers and pose.
  longint unsigned mdl_dpc, mdl_rpc;
  logic [31:0] mdl_prev_l, mdl_prev_r;
  longint mdl_x, mdl_y, mdl_head;

  pose_t pending_poses[$];
  int    fail_count;
  int    result_count;
  int    sample_count;

  longint atan_tab[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
    131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

  // Arithmetic shift floors; add half first for round-to-nearest, ties up.
  function automatic longint rnd_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Rotation CORDIC on a Q16 angle, returns Q16 cosine and sine.
  task automatic rotate_unit(input longint ang, output longint c, output longint s);
    longint z, x, y, t;
    bit flip;
    z = ang * (64'sd1 <<< 14);
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 1686629713) begin
      z -= 2 * 64'sd1686629713;
      flip = 1;
    end else if (z < -1686629713) begin
      z += 2 * 64'sd1686629713;
      flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_tab[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_tab[i];
      end
      x = t;
    end
    c = rnd_shift(x, 14);
    s = rnd_shift(y, 14);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endtask

  // Advance the shadow pose by one sample and queue the expected result.
  task automatic predict_pose(input logic [95:0] d);
    longint dl, dr, ls, rs, dist_step, dh, c, s, v, w;
    pose_t p;
    dl = longint'($signed(d[31:0] - mdl_prev_l));
    dr = longint'($signed(d[63:32] - mdl_prev_r));
    ls = longint'($signed(d[79:64]));
    rs = longint'($signed(d[95:80]));
    mdl_prev_l = d[31:0];
    mdl_prev_r = d[63:32];
    dist_step = clip(rnd_shift((dl + dr) * longint'(mdl_dpc), 9), -DIST_MAX, DIST_MAX);
    rotate_unit(mdl_head, c, s);
    mdl_x = clip(mdl_x + rnd_shift(dist_step * c, 16), I32_MIN, I32_MAX);
    mdl_y = clip(mdl_y + rnd_shift(dist_step * s, 16), I32_MIN, I32_MAX);
    dh = clip(rnd_shift((dr - dl) * longint'(mdl_rpc), 8), -2 * PI_L, 2 * PI_L - 1);
    mdl_head += dh;
    if (mdl_head >= PI_L) mdl_head -= 2 * PI_L;
    else if (mdl_head < -PI_L) mdl_head += 2 * PI_L;
    v = rnd_shift((ls + rs) * longint'(mdl_dpc), 9);
    w = rnd_shift((rs - ls) * longint'(mdl_rpc), 8);
    p.x_pos = mdl_x[31:0];
    p.y_pos = mdl_y[31:0];
    p.heading = mdl_head[18:0];
    p.lin_vel = 32'(clip(v, I32_MIN, I32_MAX));
    p.ang_vel = 32'(clip(w, I32_MIN, I32_MAX));
    pending_poses.push_back(p);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    fail_count++;
    $display("mismatch %s at result %0d: got %0h, expected %0h",
             what, result_count, got, want);
  endtask

  // Drive one sample after a random gap and hold it until accepted.
  task automatic send_sample(input logic [31:0] lc, input logic [31:0] rc,
                             input logic [15:0] ls, input logic [15:0] rs);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rs, ls, rc, lc};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_pose({rs, ls, rc, lc});
    sample_count++;
  endtask

  // Drop the input, wait until every queued result has arrived, then settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [23:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == CFG_DPC) mdl_dpc = val;
    else mdl_rpc = val;
  endtask

  task automatic set_config(input logic [23:0] dpc, input logic [23:0] rpc);
    wait_idle();
    write_reg(CFG_DPC, dpc);
    write_reg(CFG_RPC, rpc);
    cfg_we_i <= 1'b0;
  endtask

  // Receiver: stall at random, compare every accepted result.
  initial begin
    pose_t got, want;
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 4);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got = m_axis_tdata[146:0];
      if (pending_poses.size() == 0) begin
        report_mismatch("unexpected result", got.x_pos, 0);
      end else begin
        want = pending_poses.pop_front();
        if (got.x_pos !== want.x_pos) report_mismatch("x", got.x_pos, want.x_pos);
        if (got.y_pos !== want.y_pos) report_mismatch("y", got.y_pos, want.y_pos);
        if (got.heading !== want.heading)
          report_mismatch("heading", got.heading, want.heading);
        if (got.lin_vel !== want.lin_vel)
          report_mismatch("lin_vel", got.lin_vel, want.lin_vel);
        if (got.ang_vel !== want.ang_vel)
          report_mismatch("ang_vel", got.ang_vel, want.ang_vel);
      end
      result_count++;
    end
  end

  // First sample runs against zero counts with zero registers.
  task automatic test_reset_defaults();
    send_sample(32'd1000, 32'd2000, 16'd100, 16'hFF00);
    send_sample(32'd0, 32'd0, 16'd0, 16'd0);
  endtask

  // Field extremes, huge jumps (distance and heading clamps), wraps.
  task automatic test_extremes();
    set_config(24'hFFFFFF, 24'hFFFFFF);
    send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF);
    send_sample(32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 16'h7FFF);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF, 16'h8000);
    for (int i = 0; i < 6; i++)
      send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0001, 16'hFFFF);
    send_sample(32'h0000_0000, 32'h0000_0000, 16'h0, 16'h0);
    set_config(24'h000001, 24'h000001);
    send_sample(32'd1, 32'd3, 16'd1, 16'd2);
    send_sample(32'hFFFF_FFFF, 32'd0, 16'hFFFF, 16'd0);
    set_config(24'h0, 24'h0);
    send_sample(32'h1234_5678, 32'h9ABC_DEF0, 16'h7FFF, 16'h8000);
  endtask

  // Heading crossing +-pi in both directions with a moderate turn constant.
  task automatic test_heading_wrap();
    logic [31:0] l, r;
    set_config(24'h010000, 24'h400000);
    l = 0;
    r = 0;
    for (int i = 0; i < 8; i++) begin
      r += 32'd5000;
      send_sample(l, r, 16'd10, 16'd20);
    end
    for (int i = 0; i < 8; i++) begin
      l += 32'd9000;
      send_sample(l, r, 16'd20, 16'd10);
    end
  endtask

  // Random driving with occasional count jumps; change registers per phase.
  task automatic test_random_drive(input int n);
    logic [31:0] l, r;
    logic [15:0] ls, rs;
    l = $urandom;
    r = $urandom;
    for (int i = 0; i < n; i++) begin
      if (i % 300 == 0) begin
        case ($urandom_range(0, 3))
          0: set_config(24'($urandom), 24'($urandom));
          1: set_config(24'($urandom_range(0, 4096)), 24'($urandom_range(0, 65536)));
          2: set_config(24'hFFFFFF, 24'($urandom_range(0, 255)));
          default: set_config(24'($urandom_range(0, 255)), 24'hFFFFFF);
        endcase
      end
      if ($urandom_range(0, 9) == 0) begin
        l = $urandom;
        r = $urandom;
        ls = 16'($urandom);
        rs = 16'($urandom);
      end else begin
        l += $urandom_range(0, 400) - 200;
        r += $urandom_range(0, 400) - 200;
        ls = 16'($urandom_range(0, 4000) - 2000);
        rs = 16'($urandom_range(0, 4000) - 2000);
      end
      send_sample(l, r, ls, rs);
      // Hold off once mid-run until every result has drained.
      if (i == n / 2) wait_idle();
    end
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
    sample_count = 0;
    mdl_dpc = 0;
    mdl_rpc = 0;
    mdl_prev_l = 0;
    mdl_prev_r = 0;
    mdl_x = 0;
    mdl_y = 0;
    mdl_head = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_addr_i = CFG_DPC;
    cfg_wdata_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_extremes();
    test_heading_wrap();
    test_random_drive(1550);
    wait_idle();
    $display("covered %0d samples and %0d results over several register settings",
             sample_count, result_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
